>>> rtl/core/kcp_pkg.sv
// Shared types and constants for the k-core peeling unit.
// Depends on nothing; used by the output stage, the top level and the testbench.
`default_nettype none

package kcp_pkg;

    // Field widths of the item and the result
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 16;
    localparam int VAL_W    = 17;
    localparam int DEG_W    = 12;
    localparam int VCOUNT_W = 13;

    // Largest degree a vertex can hold
    localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

    // Item operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD_OFFSET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_NEIGHBOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN           = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } kcp_in_t;

    typedef struct packed {
        logic [DEG_W-1:0] core_number;
        logic [DEG_W-1:0] max_core;
        logic             error;
    } kcp_out_t;

endpackage : kcp_pkg

`default_nettype wire

>>> rtl/core/kcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module kcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : kcp_ram

`default_nettype wire

>>> rtl/core/kcp_out_reg.sv
// Output register stage for result items of the k-core peeling unit.
// Depends on kcp_pkg.
`default_nettype none

module kcp_out_reg
    import kcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire kcp_out_t load_item,
    input  wire logic     out_stall,
    output logic          out_valid,
    output kcp_out_t      out_item,
    output logic          free
);

    logic     valid_reg;
    logic     valid_next;
    kcp_out_t item_reg;

    // stage is free when empty or its item leaves this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule : kcp_out_reg

`default_nettype wire

>>> rtl/core/k_core_peeling_unit.sv
// k-core peeling unit: offset, neighbor, degree and queue RAMs with a sequencer.
// Loads write from idle (bad ones give an error result); a query reads degrees via
// S_QUERY, or answers from idle if out of range or unrun. A run of zero vertices
// answers from idle, else sets degrees from offsets, then per level scans, peels each
// queued vertex by its list and closes. One item at a time; a stalled result holds the input.
// Reset clears control state; graph RAMs hold nothing until loaded, and degrees at or
// above the highest vertex count ever run read as zero (fill mark).
`default_nettype none

module k_core_peeling_unit
    import kcp_pkg::*;
#(
    parameter int MAX_VERTICES     = 4096,
    parameter int MAX_EDGE_ENTRIES = 65536
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire kcp_in_t             in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output kcp_out_t                 out_item,
    input  wire logic                cfg_we,
    input  wire logic [VCOUNT_W-1:0] cfg_wdata
);

    localparam int VIDW = $clog2(MAX_VERTICES);
    localparam int NW   = VIDW + 1;
    localparam int AW_O = $clog2(MAX_VERTICES + 1);
    localparam int AW_E = (MAX_EDGE_ENTRIES > 1) ? $clog2(MAX_EDGE_ENTRIES) : 1;
    localparam logic [31:0] MAXV32 = 32'(MAX_VERTICES);
    localparam logic [31:0] MAXE32 = 32'(MAX_EDGE_ENTRIES);

    typedef enum logic [16:0] {
        S_IDLE       = 17'b00000000000000001,
        S_QUERY      = 17'b00000000000000010,
        S_INIT0      = 17'b00000000000000100,
        S_INIT0W     = 17'b00000000000001000,
        S_INITR      = 17'b00000000000010000,
        S_INITW      = 17'b00000000000100000,
        S_SCAN_START = 17'b00000000001000000,
        S_SCANR      = 17'b00000000010000000,
        S_SCANW      = 17'b00000000100000000,
        S_DRAIN      = 17'b00000001000000000,
        S_QW         = 17'b00000010000000000,
        S_STW        = 17'b00000100000000000,
        S_ENW        = 17'b00001000000000000,
        S_NB         = 17'b00010000000000000,
        S_NBW        = 17'b00100000000000000,
        S_DEGW       = 17'b01000000000000000,
        S_LEND       = 17'b10000000000000000
    } state_t;

    // clamp of the vertex count; bad flags zero or too large
    function automatic logic [NW:0] clamp_count(input logic [VCOUNT_W-1:0] vc);
        logic [NW:0] r;
        r = {1'b0, {NW{1'b0}}};
        if (vc == '0)
        begin
            r = {1'b1, {NW{1'b0}}};
        end
        else if (32'(vc) > MAXV32)
        begin
            r = {1'b1, NW'(MAX_VERTICES)};
        end
        else
        begin
            r = {1'b0, NW'(vc)};
        end
        return r;
    endfunction

    // registers
    state_t               state_reg, state_next;
    logic [VCOUNT_W-1:0]  vcount_reg;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        v_reg, v_next;
    logic [NW-1:0]        head_reg, head_next;
    logic [NW-1:0]        tail_reg, tail_next;
    logic [NW:0]          removed_reg, removed_next;
    logic [NW-1:0]        hw_reg, hw_next;
    logic [DEG_W-1:0]     level_reg, level_next;
    logic [DEG_W-1:0]     max_reg, max_next;
    logic                 bad_reg, bad_next;
    logic [VAL_W-1:0]     prev_reg, prev_next;
    logic [VAL_W-1:0]     en_reg, en_next;
    logic [VAL_W-1:0]     j_reg, j_next;
    logic [VIDW-1:0]      w_reg, w_next;
    logic [VIDW-1:0]      u_reg, u_next;

    // RAM ports
    logic                 off_we;
    logic [AW_O-1:0]      off_waddr, off_raddr;
    logic [VAL_W-1:0]     off_wdata, off_rdata;
    logic                 nb_we;
    logic [AW_E-1:0]      nb_waddr, nb_raddr;
    logic [VIDW-1:0]      nb_wdata, nb_rdata;
    logic                 deg_we;
    logic [VIDW-1:0]      deg_waddr, deg_raddr;
    logic [DEG_W-1:0]     deg_wdata, deg_rdata;
    logic                 q_we;
    logic [VIDW-1:0]      q_waddr, q_raddr;
    logic [VIDW-1:0]      q_wdata, q_rdata;

    // result path
    logic                 res_load;
    kcp_out_t             res_item;
    logic                 out_free;
    logic                 accept;

    kcp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    kcp_ram #(.WIDTH(VIDW), .DEPTH(MAX_EDGE_ENTRIES)) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    kcp_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    kcp_ram #(.WIDTH(VIDW), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    kcp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_item (res_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .free      (out_free)
    );

    // take an item only when idle and the output stage has room
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    // sequencer
    always_comb
    begin
        logic [NW:0]      cl;
        logic [VAL_W-1:0] d17;
        logic [DEG_W-1:0] dsat;
        logic [NW-1:0]    vinc;
        logic [NW:0]      rsum;

        state_next   = state_reg;
        n_next       = n_reg;
        v_next       = v_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        removed_next = removed_reg;
        hw_next      = hw_reg;
        level_next   = level_reg;
        max_next     = max_reg;
        bad_next     = bad_reg;
        prev_next    = prev_reg;
        en_next      = en_reg;
        j_next       = j_reg;
        w_next       = w_reg;
        u_next       = u_reg;

        off_we    = 1'b0;
        off_waddr = AW_O'(in_item.index);
        off_wdata = in_item.value;
        off_raddr = AW_O'(v_reg);
        nb_we     = 1'b0;
        nb_waddr  = AW_E'(in_item.index);
        nb_wdata  = VIDW'(in_item.value);
        nb_raddr  = AW_E'(j_reg);
        deg_we    = 1'b0;
        deg_waddr = VIDW'(v_reg);
        deg_wdata = '0;
        deg_raddr = VIDW'(v_reg);
        q_we      = 1'b0;
        q_waddr   = VIDW'(tail_reg);
        q_wdata   = VIDW'(v_reg);
        q_raddr   = VIDW'(head_reg);

        res_load             = 1'b0;
        res_item.core_number = '0;
        res_item.max_core    = max_reg;
        res_item.error       = 1'b0;

        cl   = clamp_count(vcount_reg);
        d17  = '0;
        dsat = '0;
        vinc = v_reg + NW'(1);
        rsum = removed_reg + {1'b0, tail_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.mode)
                        MODE_LOAD_OFFSET:
                        begin
                            if ({16'd0, in_item.index} > MAXV32
                                || {15'd0, in_item.value} > MAXE32)
                            begin
                                res_load       = 1'b1;
                                res_item.error = 1'b1;
                            end
                            else
                            begin
                                off_we = 1'b1;
                            end
                        end
                        MODE_LOAD_NEIGHBOR:
                        begin
                            if ({16'd0, in_item.index} >= MAXE32
                                || {15'd0, in_item.value} >= MAXV32)
                            begin
                                res_load       = 1'b1;
                                res_item.error = 1'b1;
                            end
                            else
                            begin
                                nb_we = 1'b1;
                            end
                        end
                        MODE_RUN:
                        begin
                            n_next       = cl[NW-1:0];
                            bad_next     = cl[NW];
                            level_next   = '0;
                            removed_next = '0;
                            max_next     = '0;
                            v_next       = '0;
                            if (cl[NW-1:0] == '0)
                            begin
                                res_load          = 1'b1;
                                res_item.max_core = '0;
                                res_item.error    = cl[NW];
                            end
                            else
                            begin
                                state_next = S_INIT0;
                            end
                        end
                        MODE_QUERY:
                        begin
                            deg_raddr = VIDW'(in_item.index);
                            if (32'(in_item.index) >= 32'(cl[NW-1:0]))
                            begin
                                res_load       = 1'b1;
                                res_item.error = 1'b1;
                            end
                            else if (32'(in_item.index) >= 32'(hw_reg))
                            begin
                                // never written by a run: degree is zero
                                res_load = 1'b1;
                            end
                            else
                            begin
                                state_next = S_QUERY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_QUERY:
            begin
                res_load             = 1'b1;
                res_item.core_number = deg_rdata;
                state_next           = S_IDLE;
            end

            // initial degrees from consecutive offsets
            S_INIT0:
            begin
                off_raddr  = '0;
                state_next = S_INIT0W;
            end

            S_INIT0W:
            begin
                prev_next  = off_rdata;
                state_next = S_INITR;
            end

            S_INITR:
            begin
                off_raddr  = AW_O'(vinc);
                state_next = S_INITW;
            end

            S_INITW:
            begin
                if (off_rdata > prev_reg)
                begin
                    d17 = off_rdata - prev_reg;
                end
                if (d17 > VAL_W'(DEG_MAX))
                begin
                    dsat     = DEG_MAX;
                    bad_next = 1'b1;
                end
                else
                begin
                    dsat = d17[DEG_W-1:0];
                end
                deg_we    = 1'b1;
                deg_waddr = VIDW'(v_reg);
                deg_wdata = dsat;
                prev_next = off_rdata;
                v_next    = vinc;
                if (vinc == n_reg)
                begin
                    if (n_reg > hw_reg)
                    begin
                        hw_next = n_reg;
                    end
                    state_next = S_SCAN_START;
                end
                else
                begin
                    state_next = S_INITR;
                end
            end

            // queue every vertex at the current level
            S_SCAN_START:
            begin
                head_next  = '0;
                tail_next  = '0;
                v_next     = '0;
                state_next = S_SCANR;
            end

            S_SCANR:
            begin
                deg_raddr  = VIDW'(v_reg);
                state_next = S_SCANW;
            end

            S_SCANW:
            begin
                if (deg_rdata == level_reg)
                begin
                    q_we      = 1'b1;
                    q_waddr   = VIDW'(tail_reg);
                    q_wdata   = VIDW'(v_reg);
                    tail_next = tail_reg + NW'(1);
                end
                v_next     = vinc;
                state_next = (vinc == n_reg) ? S_DRAIN : S_SCANR;
            end

            // pop the next queued vertex
            S_DRAIN:
            begin
                q_raddr = VIDW'(head_reg);
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + NW'(1);
                    state_next = S_QW;
                end
                else
                begin
                    state_next = S_LEND;
                end
            end

            S_QW:
            begin
                w_next     = q_rdata;
                off_raddr  = AW_O'(q_rdata);
                state_next = S_STW;
            end

            S_STW:
            begin
                j_next     = off_rdata;
                off_raddr  = AW_O'({1'b0, w_reg} + NW'(1));
                state_next = S_ENW;
            end

            S_ENW:
            begin
                if ({15'd0, off_rdata} > MAXE32)
                begin
                    en_next = MAXE32[VAL_W-1:0];
                end
                else
                begin
                    en_next = off_rdata;
                end
                state_next = S_NB;
            end

            // walk the adjacency list
            S_NB:
            begin
                nb_raddr   = AW_E'(j_reg);
                state_next = (j_reg < en_reg) ? S_NBW : S_DRAIN;
            end

            S_NBW:
            begin
                u_next    = nb_rdata;
                j_next    = j_reg + VAL_W'(1);
                deg_raddr = nb_rdata;
                if ({1'b0, nb_rdata} >= n_reg)
                begin
                    state_next = S_NB;
                end
                else
                begin
                    state_next = S_DEGW;
                end
            end

            // degree read-modify-write
            S_DEGW:
            begin
                if (deg_rdata > level_reg)
                begin
                    deg_we    = 1'b1;
                    deg_waddr = u_reg;
                    deg_wdata = deg_rdata - DEG_W'(1);
                    if ((deg_rdata - DEG_W'(1)) == level_reg && tail_reg < n_reg)
                    begin
                        q_we      = 1'b1;
                        q_waddr   = VIDW'(tail_reg);
                        q_wdata   = u_reg;
                        tail_next = tail_reg + NW'(1);
                    end
                end
                state_next = S_NB;
            end

            // close the level
            S_LEND:
            begin
                removed_next = rsum;
                max_next     = level_reg;
                if (rsum >= {1'b0, n_reg} || level_reg == DEG_MAX)
                begin
                    res_load          = 1'b1;
                    res_item.max_core = level_reg;
                    res_item.error    = bad_reg;
                    state_next        = S_IDLE;
                end
                else
                begin
                    level_next = level_reg + DEG_W'(1);
                    state_next = S_SCAN_START;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= VCOUNT_W'(1);
            hw_reg      <= '0;
            max_reg     <= '0;
            level_reg   <= '0;
            removed_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            bad_reg     <= 1'b0;
            n_reg       <= '0;
            v_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            max_reg     <= max_next;
            level_reg   <= level_next;
            removed_reg <= removed_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            bad_reg     <= bad_next;
            n_reg       <= n_next;
            v_reg       <= v_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        en_reg   <= en_next;
        j_reg    <= j_next;
        w_reg    <= w_next;
        u_reg    <= u_next;
    end

endmodule : k_core_peeling_unit

`default_nettype wire

>>> dv/k_core_peeling_unit_test.sv
// Self-checking testbench for the k-core peeling unit: loads graphs, peels and queries.
// Depends on kcp_pkg and k_core_peeling_unit; carries its own model of the peeling.
`default_nettype none

module k_core_peeling_unit_test;
    import kcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV         = 4096;
    localparam int NE         = 65536;
    localparam int STRAY_ID   = 4095;
    localparam int PREFILL_NB = 5001;
    localparam int WATCH_MAX  = 200000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    kcp_in_t             in_item;
    logic                out_valid;
    logic                out_stall;
    kcp_out_t            out_item;
    logic                cfg_we;
    logic [VCOUNT_W-1:0] cfg_wdata;

    k_core_peeling_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the graph and peeling state
    int unsigned   offs_mem [0:NV];
    int unsigned   nbr_mem  [0:NE-1];
    int unsigned   deg_mem  [0:NV-1];
    int unsigned   peel_q   [0:NV-1];
    int unsigned   core_max;
    int unsigned   vcount;
    kcp_out_t      core_results [$];
    bit            failed;
    bit            quiet;
    int            idle_cycles;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Vertex count clamped to the store size; flags zero or oversize
    function automatic int unsigned live_count(output bit bad);
        bad = 1'b0;
        if (vcount == 0)
        begin
            bad = 1'b1;
            return 0;
        end
        if (vcount > NV)
        begin
            bad = 1'b1;
            return NV;
        end
        return vcount;
    endfunction

    // Level-by-level peeling of the shadow graph; returns the error flag
    function automatic bit peel_graph();
        bit          bad;
        int unsigned n, v, st, en, d, head, tail, level, removed, w, j, u;
        n = live_count(bad);
        for (v = 0; v < n; v++)
        begin
            st = offs_mem[v];
            en = offs_mem[v + 1];
            d  = (en > st) ? en - st : 0;
            if (d > DEG_MAX)
            begin
                d   = DEG_MAX;
                bad = 1'b1;
            end
            deg_mem[v] = d;
        end
        removed  = 0;
        level    = 0;
        core_max = 0;
        if (n == 0)
            return bad;
        forever
        begin
            head = 0;
            tail = 0;
            for (v = 0; v < n; v++)
                if (deg_mem[v] == level)
                begin
                    peel_q[tail] = v;
                    tail++;
                end
            while (head < tail)
            begin
                w = peel_q[head];
                head++;
                st = offs_mem[w];
                en = offs_mem[w + 1];
                if (en > NE)
                    en = NE;
                for (j = st; j < en; j++)
                begin
                    u = nbr_mem[j];
                    if (u < n && deg_mem[u] > level)
                    begin
                        deg_mem[u]--;
                        if (deg_mem[u] == level && tail < n)
                        begin
                            peel_q[tail] = u;
                            tail++;
                        end
                    end
                end
            end
            removed += tail;
            core_max = level;
            if (removed >= n || level >= DEG_MAX)
                break;
            level++;
        end
        return bad;
    endfunction

    // Update the shadow state for one item and queue any result it causes
    task automatic predict_item(input kcp_in_t it);
        kcp_out_t    r;
        bit          bad;
        int unsigned n;
        r = '0;
        case (it.mode)
            MODE_LOAD_OFFSET:
                if (it.index > NV || it.value > NE)
                    r.error = 1'b1;
                else
                begin
                    offs_mem[it.index] = it.value;
                    return;
                end
            MODE_LOAD_NEIGHBOR:
                if (it.index >= NE || it.value >= NV)
                    r.error = 1'b1;
                else
                begin
                    nbr_mem[it.index] = it.value;
                    return;
                end
            MODE_RUN:
                r.error = peel_graph();
            default:
            begin
                n = live_count(bad);
                if (it.index < n)
                    r.core_number = deg_mem[it.index][DEG_W-1:0];
                else
                    r.error = 1'b1;
            end
        endcase
        r.max_core = core_max[DEG_W-1:0];
        core_results.push_back(r);
    endtask

    // Send one item, idling at random before it
    task automatic send_item(input logic [MODE_W-1:0] mode, input int unsigned idx,
                             input int unsigned val);
        kcp_in_t it;
        it.mode  = mode;
        it.index = idx[IDX_W-1:0];
        it.value = val[VAL_W-1:0];
        while (!quiet && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        predict_item(it);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every expected result has come, plus load latency slack
    task automatic drain();
        in_valid <= 1'b0;
        while (core_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int unsigned cnt);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt[VCOUNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        vcount = cnt & 13'h1FFF;
    endtask

    task automatic run_and_query_all(input int unsigned nq);
        send_item(MODE_RUN, $urandom, $urandom);
        for (int q = 0; q <= nq; q++)
            send_item(MODE_QUERY, q, $urandom);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        kcp_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (core_results.size() == 0)
            begin
                $display("%t unexpected result %h", $realtime, out_item);
                failed = 1'b1;
            end
            else
            begin
                want = core_results.pop_front();
                if (out_item.core_number !== want.core_number)
                begin
                    $display("%t core_number expected %0d actual %0d", $realtime,
                             want.core_number, out_item.core_number);
                    failed = 1'b1;
                end
                if (out_item.max_core !== want.max_core)
                begin
                    $display("%t max_core expected %0d actual %0d", $realtime,
                             want.max_core, out_item.max_core);
                    failed = 1'b1;
                end
                if (out_item.error !== want.error)
                begin
                    $display("%t error expected %0d actual %0d", $realtime,
                             want.error, out_item.error);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 23);

    // Watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every offset and the low neighbor region get a known value once
    task automatic test_prefill();
        quiet = 1'b1;
        for (int i = 0; i <= NV; i++)
            send_item(MODE_LOAD_OFFSET, i, 0);
        for (int i = 0; i < PREFILL_NB; i++)
            send_item(MODE_LOAD_NEIGHBOR, i, STRAY_ID);
        quiet = 1'b0;
    endtask

    // Zero, oversize and full vertex counts
    task automatic test_count_extremes();
        set_vertex_count(0);
        send_item(MODE_RUN, 0, 0);
        send_item(MODE_QUERY, 0, 0);
        set_vertex_count(8191);
        send_item(MODE_RUN, 16'hFFFF, 17'h1FFFF);
        send_item(MODE_QUERY, 4095, 0);
        send_item(MODE_QUERY, 4096, 0);
        set_vertex_count(NV);
        send_item(MODE_RUN, 0, 0);
        send_item(MODE_QUERY, 16'hFFFF, 0);
    endtask

    // Out-of-range loads and edge-of-range writes
    task automatic test_load_bounds();
        send_item(MODE_LOAD_OFFSET, NV + 1, 0);
        send_item(MODE_LOAD_OFFSET, 16'hFFFF, 17'h1FFFF);
        send_item(MODE_LOAD_OFFSET, 3000, NE + 1);
        send_item(MODE_LOAD_OFFSET, NV, 0);
        send_item(MODE_LOAD_NEIGHBOR, 16'hFFFF, NV);
        send_item(MODE_LOAD_NEIGHBOR, 16'hFFFF, STRAY_ID);
        send_item(MODE_LOAD_NEIGHBOR, 0, 17'h10000);
    endtask

    // One vertex with more neighbors than a degree can hold
    task automatic test_degree_saturation();
        set_vertex_count(2);
        send_item(MODE_LOAD_OFFSET, 0, 0);
        send_item(MODE_LOAD_OFFSET, 1, 5000);
        send_item(MODE_LOAD_OFFSET, 2, 5000);
        run_and_query_all(2);
    endtask

    // Triangle with a pendant, a descending offset and a stray neighbor
    task automatic test_small_graph();
        int unsigned o [0:5];
        int unsigned nb [0:8];
        o  = '{0, 2, 4, 7, 6, 9};
        nb = '{1, 2, 0, 2, 0, 1, 3, 9, 2};
        set_vertex_count(5);
        for (int i = 0; i <= 5; i++)
            send_item(MODE_LOAD_OFFSET, o[i], 0);
        for (int i = 0; i <= 5; i++)
            send_item(MODE_LOAD_OFFSET, i, o[i]);
        for (int i = 0; i < 9; i++)
            send_item(MODE_LOAD_NEIGHBOR, i, nb[i]);
        run_and_query_all(5);
        set_vertex_count(1);
        run_and_query_all(1);
    endtask

    // Random graphs, with noise items mixed into the loads
    task automatic test_random_graphs();
        int          sent;
        int unsigned n, cnt, dmax, nq;
        int unsigned o [0:12];
        sent = 0;
        while (sent < 1350)
        begin
            quiet = (sent > 400 && sent < 600);
            n    = $urandom_range(1, 12);
            dmax = (n < 6) ? n : 6;
            o[0] = $urandom_range(0, 200);
            for (int v = 0; v < n; v++)
                if ($urandom_range(9) == 0 && o[v] > 0)
                    o[v + 1] = o[v] - $urandom_range(1, (o[v] < 3) ? o[v] : 3);
                else
                    o[v + 1] = o[v] + $urandom_range(0, dmax);
            for (int v = 0; v <= n; v++)
            begin
                send_item(MODE_LOAD_OFFSET, v, o[v]);
                sent++;
            end
            for (int v = 0; v < n; v++)
                for (int j = o[v]; j < o[v + 1]; j++)
                begin
                    send_item(MODE_LOAD_NEIGHBOR, j, $urandom_range(0, n + 1));
                    sent++;
                    if ($urandom_range(9) == 0)
                    begin
                        case ($urandom_range(2))
                            0: send_item(MODE_LOAD_OFFSET, $urandom_range(NV + 1, 65535),
                                         $urandom);
                            1: send_item(MODE_LOAD_OFFSET, $urandom_range(0, NV),
                                         $urandom_range(NE + 1, 131071));
                            default: send_item(MODE_LOAD_NEIGHBOR, $urandom_range(0, 65535),
                                               $urandom_range(0, 131071));
                        endcase
                        sent++;
                    end
                end
            cnt = ($urandom_range(4) == 0 && n > 1) ? n - 1 : n;
            set_vertex_count(cnt);
            send_item(MODE_RUN, $urandom, $urandom);
            nq = $urandom_range(1, n + 2);
            for (int q = 0; q < nq; q++)
            begin
                if ($urandom_range(7) == 0)
                    send_item(MODE_QUERY, $urandom_range(0, 65535), $urandom);
                else
                    send_item(MODE_QUERY, $urandom_range(0, cnt), $urandom);
            end
            sent += nq + 1;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        failed      = 1'b0;
        quiet       = 1'b0;
        idle_cycles = 0;
        vcount      = 1;
        core_max    = 0;
        for (int i = 0; i < NV; i++)
            deg_mem[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prefill();
        test_count_extremes();
        test_load_bounds();
        test_degree_saturation();
        test_small_graph();
        test_random_graphs();

        drain();
        repeat (20) @(posedge clk);
        if (!failed && core_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : k_core_peeling_unit_test

`default_nettype wire
